/* rtl/core/assert_macros.svh */
// assertion macros shared by the tracker rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/core/prt_pkg.sv */
// types, codes and sizes of the pending request tracker
// no dependencies
`default_nettype none
package prt_pkg;

  localparam int SLOTS    = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_OUT  = 8;
  localparam int CNT_W    = $clog2(MAX_OUT + 1);
  localparam int FQ_AW    = 1;
  localparam int FQ_DEPTH = 1 << FQ_AW;
  localparam int RQ_AW    = 1;
  localparam int RQ_DEPTH = 1 << RQ_AW;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // input command codes
  localparam logic [1:0] CMD_SUBMIT = 2'd0;
  localparam logic [1:0] CMD_RESP   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SUBMIT  = 2'd0;
  localparam logic [1:0] KIND_RESP    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // submit status
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_TGT = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_REFUSED = 2'd3;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_LOCAL_NODE      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DEFAULT_TIMEOUT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BROADCAST_NODE  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_NODE        = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_NODE        = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TIMEOUT_CODE    = 3'd5;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_RESP   = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  node_id;
    logic [7:0]  msg_target_node;
    logic [7:0]  msg_request_id;
    logic [7:0]  cmd_code;
    logic        reply_req;
    logic        tx_ready;
    logic [7:0]  reply_result;
    logic [7:0]  reply_detail;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] req_id;
    logic [7:0] source_node;
    logic [7:0] target_node;
    logic [7:0] op_code;
    logic [7:0] res_code;
    logic [7:0] det_code;
    logic       tracked;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  local_node;
    logic [31:0] default_timeout;
    logic [7:0]  broadcast_node;
    logic [7:0]  min_node;
    logic [7:0]  max_node;
    logic [7:0]  timeout_code;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    op_t      op;
    logic     tgt_ok;
    logic     want;
    in_word_t w;
  } cls_t;

endpackage
`default_nettype wire

/* rtl/core/prt_front.sv */
// front end: accepts input words, classifies them, queues them for the back end
// depends on prt_pkg
`default_nettype none
module prt_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire prt_pkg::cfg_t     cfg,
  input  wire logic              push,
  output logic                   full,
  input  wire prt_pkg::in_word_t in_word,
  output logic                   q_valid,
  output prt_pkg::cls_t          q_item,
  input  wire logic              q_take
);
  import prt_pkg::*;

  cls_t             mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_r;
  logic [FQ_AW-1:0] rd_r;
  logic [FQ_AW:0]   cnt_r;
  cls_t             cls_new;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (cnt_r == (FQ_AW + 1)'(FQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];
  assign push_ok = push && !full;
  assign pop_ok  = q_take && q_valid;

  // target check, tracking decision and command decode
  always_comb begin
    cls_new.w      = in_word;
    cls_new.tgt_ok = (in_word.node_id == cfg.broadcast_node) ||
                     ((in_word.node_id >= cfg.min_node) &&
                      (in_word.node_id <= cfg.max_node));
    cls_new.want   = in_word.reply_req && (in_word.node_id != cfg.broadcast_node);
    case (in_word.command)
      CMD_SUBMIT: cls_new.op = OP_SUBMIT;
      CMD_RESP:   cls_new.op = OP_RESP;
      CMD_TICK:   cls_new.op = OP_TICK;
      default:    cls_new.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= cls_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/prt_resq.sv */
// result queue between the back end and the result ports
// depends on prt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module prt_resq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rq_push,
  input  wire prt_pkg::out_word_t rq_word,
  output logic                    rq_full,
  output logic                    empty,
  input  wire logic               pop,
  output prt_pkg::out_word_t      out_word
);
  import prt_pkg::*;

  out_word_t        mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_r;
  logic [RQ_AW-1:0] rd_r;
  logic [RQ_AW:0]   cnt_r;
  logic             push_ok;
  logic             pop_ok;

  assign rq_full  = (cnt_r == (RQ_AW + 1)'(RQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_word = mem_r[rd_r];
  assign push_ok  = rq_push && !rq_full;
  assign pop_ok   = pop && !empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= rq_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rq_cnt_bound, clk, rst_n, cnt_r <= (RQ_AW + 1)'(RQ_DEPTH), "result queue overflow")

endmodule
`default_nettype wire

/* rtl/core/prt_back.sv */
// back end: slot table, id counter and the sequencer that walks the slots
// depends on prt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module prt_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire prt_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire prt_pkg::cls_t  q_item,
  output logic                q_take,
  input  wire logic           rq_full,
  output logic                rq_push,
  output prt_pkg::out_word_t  rq_word
);
  import prt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RESP  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              hold_vld_r, hold_vld_nxt;
  out_word_t         hold_r, hold_nxt;
  in_word_t          itm_r, itm_nxt;
  logic [31:0]       cur_time_r, cur_time_nxt;
  logic [7:0]        next_id_r, next_id_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;

  logic [7:0]        sid_r   [SLOTS];
  logic [7:0]        peer_r  [SLOTS];
  logic [7:0]        cmd_r   [SLOTS];
  logic [31:0]       start_r [SLOTS];
  logic [31:0]       limit_r [SLOTS];

  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic [7:0]        id_cur, id_inc, id_adv;
  logic [1:0]        sub_status;
  logic [7:0]        sub_rid;
  logic              sub_trk, sub_draw, sub_take;
  out_word_t         sub_word, resp_word, tmo_word;
  logic [7:0]        rd_sid, rd_peer, rd_cmd;
  logic [31:0]       rd_age;
  logic              resp_hit, tmo_hit, idx_last, cap_hit, slot_wr;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // id counter never hands out zero
  assign id_cur = (next_id_r == 8'd0) ? 8'd1 : next_id_r;
  assign id_inc = id_cur + 8'd1;
  assign id_adv = (id_inc == 8'd0) ? 8'd1 : id_inc;

  always_comb begin
    sub_status = STAT_OK;
    sub_rid    = 8'd0;
    sub_trk    = 1'b0;
    sub_draw   = 1'b0;
    sub_take   = 1'b0;
    if (!q_item.tgt_ok) begin
      sub_status = STAT_BAD_TGT;
    end else if (q_item.want && !free_any) begin
      sub_status = STAT_FULL;
    end else begin
      sub_draw = q_item.want;
      if (!q_item.w.tx_ready) begin
        sub_status = STAT_REFUSED;
      end else if (q_item.want) begin
        sub_take = 1'b1;
        sub_rid  = id_cur;
        sub_trk  = 1'b1;
      end
    end
  end

  always_comb begin
    sub_word.kind        = KIND_SUBMIT;
    sub_word.status      = sub_status;
    sub_word.req_id      = sub_rid;
    sub_word.source_node = cfg.local_node;
    sub_word.target_node = q_item.w.node_id;
    sub_word.op_code     = q_item.w.cmd_code;
    sub_word.res_code    = 8'd0;
    sub_word.det_code    = 8'd0;
    sub_word.tracked     = sub_trk;
    sub_word.last        = 1'b1;
  end

  // slot read at the walk index
  assign rd_sid   = sid_r[idx_r];
  assign rd_peer  = peer_r[idx_r];
  assign rd_cmd   = cmd_r[idx_r];
  assign rd_age   = itm_r.now_ms - start_r[idx_r];
  assign resp_hit = busy_r[idx_r] && (rd_sid == itm_r.msg_request_id) &&
                    (rd_peer == itm_r.node_id);
  assign tmo_hit  = busy_r[idx_r] && (rd_age >= limit_r[idx_r]);
  assign idx_last = (idx_r == SLOT_W'(SLOTS - 1));
  assign cap_hit  = ((cnt_r + 1'b1) == CNT_W'(MAX_OUT));

  always_comb begin
    resp_word.kind        = KIND_RESP;
    resp_word.status      = STAT_OK;
    resp_word.req_id      = itm_r.msg_request_id;
    resp_word.source_node = itm_r.node_id;
    resp_word.target_node = itm_r.msg_target_node;
    resp_word.op_code     = rd_cmd;
    resp_word.res_code    = itm_r.reply_result;
    resp_word.det_code    = itm_r.reply_detail;
    resp_word.tracked     = 1'b0;
    resp_word.last        = 1'b1;

    tmo_word.kind         = KIND_TIMEOUT;
    tmo_word.status       = STAT_OK;
    tmo_word.req_id       = rd_sid;
    tmo_word.source_node  = rd_peer;
    tmo_word.target_node  = cfg.local_node;
    tmo_word.op_code      = rd_cmd;
    tmo_word.res_code     = cfg.timeout_code;
    tmo_word.det_code     = 8'd0;
    tmo_word.tracked      = 1'b0;
    tmo_word.last         = 1'b0;
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    itm_nxt      = itm_r;
    cur_time_nxt = cur_time_r;
    next_id_nxt  = next_id_r;
    busy_nxt     = busy_r;
    q_take       = 1'b0;
    rq_push      = 1'b0;
    rq_word      = sub_word;
    slot_wr      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_SUBMIT: begin
              if (!rq_full) begin
                q_take  = 1'b1;
                rq_push = 1'b1;
                if (sub_draw) begin
                  next_id_nxt = id_adv;
                end
                if (sub_take) begin
                  slot_wr            = 1'b1;
                  busy_nxt[free_idx] = 1'b1;
                end
              end
            end
            OP_RESP: begin
              q_take    = 1'b1;
              itm_nxt   = q_item.w;
              idx_nxt   = '0;
              state_nxt = ST_RESP;
            end
            OP_TICK: begin
              q_take       = 1'b1;
              itm_nxt      = q_item.w;
              cur_time_nxt = q_item.w.now_ms;
              idx_nxt      = '0;
              cnt_nxt      = '0;
              state_nxt    = ST_SCAN;
            end
            default: begin
              q_take = 1'b1;
            end
          endcase
        end
      end
      ST_RESP: begin
        if (resp_hit) begin
          if (!rq_full) begin
            rq_push         = 1'b1;
            rq_word         = resp_word;
            busy_nxt[idx_r] = 1'b0;
            state_nxt       = ST_IDLE;
          end
        end else if (idx_last) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SCAN: begin
        // a found timeout waits in hold until the next one or the end of the walk
        if (tmo_hit) begin
          if (!hold_vld_r || !rq_full) begin
            rq_push         = hold_vld_r;
            rq_word         = hold_r;
            hold_nxt        = tmo_word;
            hold_vld_nxt    = 1'b1;
            busy_nxt[idx_r] = 1'b0;
            cnt_nxt         = cnt_r + 1'b1;
            if (idx_last || cap_hit) begin
              state_nxt = ST_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else if (idx_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (!rq_full) begin
          rq_push      = 1'b1;
          rq_word      = hold_r;
          rq_word.last = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_wr) begin
      sid_r[free_idx]   <= id_cur;
      peer_r[free_idx]  <= q_item.w.node_id;
      cmd_r[free_idx]   <= q_item.w.cmd_code;
      start_r[free_idx] <= cur_time_r;
      limit_r[free_idx] <= cfg.default_timeout;
    end
    hold_r <= hold_nxt;
    itm_r  <= itm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      cnt_r      <= '0;
      hold_vld_r <= 1'b0;
      cur_time_r <= 32'd0;
      next_id_r  <= 8'd1;
      busy_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
      hold_vld_r <= hold_vld_nxt;
      cur_time_r <= cur_time_nxt;
      next_id_r  <= next_id_nxt;
      busy_r     <= busy_nxt;
    end
  end

  `ASSERT_IMPLIES(a_hold_in_walk, clk, rst_n, hold_vld_r, state_r == ST_SCAN || state_r == ST_FLUSH, "held timeout outside tick walk")
  `ASSERT_ALWAYS(a_id_nonzero, clk, rst_n, next_id_r != 8'd0, "id counter holds zero")
  `ASSERT_IMPLIES(a_push_room, clk, rst_n, rq_push, !rq_full, "push into full result queue")
  `ASSERT_ALWAYS(a_cnt_cap, clk, rst_n, cnt_r <= CNT_W'(MAX_OUT), "too many timeouts in one tick")

endmodule
`default_nettype wire

/* rtl/core/pending_request_tracker_core.sv */
// path: a submit result reaches the ports through the input queue and the result queue;
// a response or a tick first walks the slots, one slot visited per cycle unless the
// result queue is full; throughput: a submit every cycle while the result queue has room;
// a response or a tick holds the back end while it walks the slots, longer while the queue is full
// reset: synchronous, active low; queues empty, all slots free, id counter 1, time 0,
// registers at their defaults; slot contents are not cleared, only the busy flags
`default_nettype none
module pending_request_tracker_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input queue side
  input  wire logic                          push,
  output logic                               full,
  input  wire prt_pkg::in_word_t             in_word,
  // result queue side
  output logic                               empty,
  input  wire logic                          pop,
  output prt_pkg::out_word_t                 out_word,
  // register writes
  input  wire logic                          cfg_we,
  input  wire logic [prt_pkg::CFG_AW-1:0]    cfg_index,
  input  wire logic [prt_pkg::CFG_DW-1:0]    cfg_wdata
);
  import prt_pkg::*;

  cfg_t      cfg_r;
  logic      q_valid;
  cls_t      q_item;
  logic      q_take;
  logic      rq_full;
  logic      rq_push;
  out_word_t rq_word;

  // register file; the user must write only while the block is quiet, the block does not
  // enforce it, so both ends may use the values without any staging
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_node      <= 8'd0;
      cfg_r.default_timeout <= 32'd1000;
      cfg_r.broadcast_node  <= 8'd255;
      cfg_r.min_node        <= 8'd1;
      cfg_r.max_node        <= 8'd254;
      cfg_r.timeout_code    <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_NODE:      cfg_r.local_node      <= cfg_wdata[7:0];
        REG_DEFAULT_TIMEOUT: cfg_r.default_timeout <= cfg_wdata;
        REG_BROADCAST_NODE:  cfg_r.broadcast_node  <= cfg_wdata[7:0];
        REG_MIN_NODE:        cfg_r.min_node        <= cfg_wdata[7:0];
        REG_MAX_NODE:        cfg_r.max_node        <= cfg_wdata[7:0];
        REG_TIMEOUT_CODE:    cfg_r.timeout_code    <= cfg_wdata[7:0];
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  // front end: target check and command decode at the input, then a two word queue
  prt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  // back end: response and tick walk the slots one per cycle while the result queue has room
  prt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .rq_full (rq_full),
    .rq_push (rq_push),
    .rq_word (rq_word)
  );

  // result queue decouples the back end from the consumer
  prt_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .rq_push  (rq_push),
    .rq_word  (rq_word),
    .rq_full  (rq_full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench for pending_request_tracker_core: directed and random words are checked
// against an in-bench model of the slot table, id counter and tick time
// depends on prt_pkg and the core rtl
`timescale 1ns / 1ps
module testbench;
  import prt_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  in_word_t          in_word;
  logic              empty;
  logic              pop;
  out_word_t         out_word;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  pending_request_tracker_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the registers and the slot table
  cfg_t        regs_sh;
  bit          slot_used [SLOTS];
  logic [7:0]  slot_rid  [SLOTS];
  logic [7:0]  slot_node [SLOTS];
  logic [7:0]  slot_opc  [SLOTS];
  logic [31:0] slot_t0   [SLOTS];
  logic [31:0] slot_tmo  [SLOTS];
  logic [7:0]  next_rid;
  logic [31:0] now_sh;

  out_word_t results_due [$];   // results the tracker still owes, oldest first
  out_word_t due_word;
  int        fail_cnt;
  int        pop_wait;
  bit        quiet;             // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // id counter wraps and never hands out zero
  function automatic logic [7:0] draw_rid();
    logic [7:0] id;
    logic [7:0] nx;
    id = (next_rid == 8'd0) ? 8'd1 : next_rid;
    nx = id + 8'd1;
    next_rid = (nx == 8'd0) ? 8'd1 : nx;
    return id;
  endfunction

  task automatic predict_results(input in_word_t w);
    out_word_t r;
    out_word_t held;
    bit        valid;
    bit        want;
    bit        have;
    int        slot;
    int        i;
    int        n;
    logic [7:0] id;
    r = '0;
    held = '0;
    have = 1'b0;
    slot = -1;
    n = 0;
    id = 8'd0;
    case (w.command)
      CMD_SUBMIT: begin
        r.kind = KIND_SUBMIT;
        r.status = STAT_OK;
        r.source_node = regs_sh.local_node;
        r.target_node = w.node_id;
        r.op_code = w.cmd_code;
        r.last = 1'b1;
        valid = (w.node_id == regs_sh.broadcast_node) ||
                (w.node_id >= regs_sh.min_node && w.node_id <= regs_sh.max_node);
        if (!valid) begin
          r.status = STAT_BAD_TGT;
        end else begin
          // broadcast is never tracked
          want = w.reply_req && (w.node_id != regs_sh.broadcast_node);
          if (want) begin
            for (i = 0; i < SLOTS; i++)
              if (!slot_used[i] && slot < 0) slot = i;
          end
          if (want && slot < 0) begin
            r.status = STAT_FULL;   // counter does not move
          end else begin
            if (want) id = draw_rid();
            if (!w.tx_ready) begin
              r.status = STAT_REFUSED;  // id stays consumed
            end else if (want) begin
              slot_used[slot] = 1'b1;
              slot_rid[slot]  = id;
              slot_node[slot] = w.node_id;
              slot_opc[slot]  = w.cmd_code;
              slot_t0[slot]   = now_sh;
              slot_tmo[slot]  = regs_sh.default_timeout;
              r.req_id = id;
              r.tracked = 1'b1;
            end
          end
        end
        results_due.push_back(r);
      end
      CMD_RESP: begin
        // lowest busy slot matching on id and peer
        for (i = 0; i < SLOTS; i++)
          if (slot < 0 && slot_used[i] && slot_rid[i] == w.msg_request_id &&
              slot_node[i] == w.node_id) slot = i;
        if (slot >= 0) begin
          r.kind = KIND_RESP;
          r.status = STAT_OK;
          r.req_id = w.msg_request_id;
          r.source_node = w.node_id;
          r.target_node = w.msg_target_node;
          r.op_code = slot_opc[slot];
          r.res_code = w.reply_result;
          r.det_code = w.reply_detail;
          r.last = 1'b1;
          slot_used[slot] = 1'b0;
          results_due.push_back(r);
        end
      end
      CMD_TICK: begin
        now_sh = w.now_ms;
        for (i = 0; i < SLOTS; i++) begin
          // age taken modulo 2^32
          if (n < MAX_OUT && slot_used[i] && (w.now_ms - slot_t0[i]) >= slot_tmo[i]) begin
            if (have) results_due.push_back(held);
            held = '0;
            held.kind = KIND_TIMEOUT;
            held.status = STAT_OK;
            held.req_id = slot_rid[i];
            held.source_node = slot_node[i];
            held.target_node = regs_sh.local_node;
            held.op_code = slot_opc[i];
            held.res_code = regs_sh.timeout_code;
            have = 1'b1;
            slot_used[i] = 1'b0;
            n++;
          end
        end
        if (have) begin
          held.last = 1'b1;
          results_due.push_back(held);
        end
      end
      default: ;  // unused command, ignored
    endcase
  endtask

  // ---------------------------------------------------------------- words

  function automatic in_word_t noise_word();
    in_word_t   w;
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    w.command         = b[19:18];
    w.node_id         = a[7:0];
    w.msg_target_node = a[15:8];
    w.msg_request_id  = a[23:16];
    w.cmd_code        = a[31:24];
    w.reply_req       = b[16];
    w.tx_ready        = b[17];
    w.reply_result    = b[7:0];
    w.reply_detail    = b[15:8];
    w.now_ms          = $urandom;
    return w;
  endfunction

  function automatic in_word_t submit_word(input logic [7:0] node, input logic [7:0] opc,
                                           input logic need, input logic rdy);
    in_word_t w;
    w = noise_word();
    w.command = CMD_SUBMIT;
    w.node_id = node;
    w.cmd_code = opc;
    w.reply_req = need;
    w.tx_ready = rdy;
    return w;
  endfunction

  function automatic in_word_t resp_word(input logic [7:0] src, input logic [7:0] tgt,
                                         input logic [7:0] rid, input logic [7:0] res,
                                         input logic [7:0] det);
    in_word_t w;
    w = noise_word();
    w.command = CMD_RESP;
    w.node_id = src;
    w.msg_target_node = tgt;
    w.msg_request_id = rid;
    w.reply_result = res;
    w.reply_detail = det;
    return w;
  endfunction

  function automatic in_word_t tick_word(input logic [31:0] now);
    in_word_t w;
    w = noise_word();
    w.command = CMD_TICK;
    w.now_ms = now;
    return w;
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  // ---------------------------------------------------------------- drivers

  // push holds between back-to-back words so it never toggles within one step
  task automatic send_word(input in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_results(w);
  endtask

  // hold the sender until every due result is back, then let the walk settle
  task automatic drain(input int settle);
    push <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // all six registers, junk in the unused upper bits of the narrow ones
  task automatic set_regs(input cfg_t c);
    write_reg(REG_LOCAL_NODE,      {24'($urandom), c.local_node});
    write_reg(REG_DEFAULT_TIMEOUT, c.default_timeout);
    write_reg(REG_BROADCAST_NODE,  {24'($urandom), c.broadcast_node});
    write_reg(REG_MIN_NODE,        {24'($urandom), c.min_node});
    write_reg(REG_MAX_NODE,        {24'($urandom), c.max_node});
    write_reg(REG_TIMEOUT_CODE,    {24'($urandom), c.timeout_code});
    cfg_we <= 1'b0;
    regs_sh = c;
  endtask

  // ---------------------------------------------------------------- checker

  task automatic note_fail(input string what, input out_word_t e, input out_word_t a);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $write("%s: expected kind %0d st %0d id %h src %h dst %h cmd %h res %h det %h ",
             what, e.kind, e.status, e.req_id, e.source_node, e.target_node,
             e.op_code, e.res_code, e.det_code);
      $write("trk %b last %b / got kind %0d st %0d id %h src %h dst %h ",
             e.tracked, e.last, a.kind, a.status, a.req_id, a.source_node,
             a.target_node);
      $display("cmd %h res %h det %h trk %b last %b",
               a.op_code, a.res_code, a.det_code, a.tracked, a.last);
    end
  endtask

  // result side: compare each popped word, then draw the stall before the next
  always @(posedge clk) begin
    if (pop && !empty) begin
      if (results_due.size() == 0) begin
        note_fail("unexpected result", '0, out_word);
      end else begin
        due_word = results_due.pop_front();
        if (out_word.kind !== due_word.kind || out_word.status !== due_word.status ||
            out_word.req_id !== due_word.req_id ||
            out_word.source_node !== due_word.source_node ||
            out_word.target_node !== due_word.target_node ||
            out_word.op_code !== due_word.op_code ||
            out_word.res_code !== due_word.res_code ||
            out_word.det_code !== due_word.det_code ||
            out_word.tracked !== due_word.tracked || out_word.last !== due_word.last)
          note_fail("result mismatch", due_word, out_word);
      end
      pop_wait = quiet ? 0 : $urandom_range(0, 14);
    end
    if (pop_wait > 0) begin
      pop <= 1'b0;
      if (!empty) pop_wait = pop_wait - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset values, every submit outcome but a full table, responses, ticks and time wrap
  task automatic test_directed();
    send_word(submit_word(8'd1, 8'h00, 1'b1, 1'b1));      // lowest node, tracked id 1
    send_word(submit_word(8'd254, 8'hFF, 1'b1, 1'b1));    // highest node, id 2
    send_word(submit_word(8'd0, 8'hA5, 1'b1, 1'b1));      // invalid target
    send_word(submit_word(8'd255, 8'h11, 1'b1, 1'b1));    // broadcast, not tracked
    send_word(submit_word(8'd255, 8'h22, 1'b1, 1'b0));    // broadcast, refused
    send_word(submit_word(8'd10, 8'h33, 1'b0, 1'b1));     // no reply wanted
    send_word(submit_word(8'd12, 8'h44, 1'b1, 1'b0));     // refused, id 3 consumed
    send_word(resp_word(8'd1, 8'hFF, 8'd1, 8'hFF, 8'h00)); // matches slot 0
    send_word(resp_word(8'd3, 8'h00, 8'd2, 8'h00, 8'hFF)); // right id, wrong source
    begin : unused_cmd
      in_word_t w;
      w = noise_word();
      w.command = OP_NONE;
      send_word(w);
    end
    send_word(tick_word(32'd999));          // one short of the timeout
    send_word(tick_word(32'd1000));         // exactly at it
    send_word(tick_word(32'hFFFF_FF00));
    send_word(submit_word(8'd100, 8'h5C, 1'b1, 1'b1));
    send_word(tick_word(32'h0000_02E7));    // age wraps past zero, still short
    send_word(tick_word(32'h0000_02E8));
  endtask

  // fill every slot, overflow once, then retire all in one tick
  task automatic test_table_full();
    int i;
    for (i = 0; i < SLOTS; i++)
      send_word(submit_word(8'($urandom_range(1, 254)), rand8(), 1'b1, 1'b1));
    send_word(submit_word(8'd7, rand8(), 1'b1, 1'b1));
    send_word(tick_word(now_sh + regs_sh.default_timeout));
  endtask

  // mostly well formed traffic against open requests, some noise
  task automatic test_random_traffic(input cfg_t c, input int count);
    in_word_t   w;
    int         k;
    int         r;
    int         s;
    int         i;
    int         open_ix [$];
    logic [7:0] node;
    logic [31:0] step;
    drain(24);
    set_regs(c);
    k = 0;
    while (k < count) begin
      quiet = ((k / 10) % 3) == 2;
      if ($urandom_range(0, 19) == 0) drain(0);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 9) == 0 || regs_sh.min_node > regs_sh.max_node)
          node = regs_sh.broadcast_node;
        else
          node = 8'($urandom_range(regs_sh.min_node, regs_sh.max_node));
        w = submit_word(node, rand8(), $urandom_range(0, 6) != 0, $urandom_range(0, 9) != 0);
      end else if (r < 65) begin
        open_ix.delete();
        for (i = 0; i < SLOTS; i++)
          if (slot_used[i]) open_ix.push_back(i);
        if (open_ix.size() > 0 && $urandom_range(0, 4) != 0) begin
          i = open_ix[$urandom_range(0, open_ix.size() - 1)];
          w = resp_word(slot_node[i], rand8(), slot_rid[i], rand8(), rand8());
          if ($urandom_range(0, 7) == 0) w.node_id = w.node_id ^ 8'h01;  // near miss
        end else begin
          w = resp_word(rand8(), rand8(), rand8(), rand8(), rand8());
        end
      end else if (r < 85) begin
        s = $urandom_range(0, 99);
        if (s < 45)      step = 32'($urandom_range(0, 40));
        else if (s < 65) step = 32'($urandom_range(0, 3000));
        else if (s < 80) step = regs_sh.default_timeout;
        else if (s < 92) step = regs_sh.default_timeout - 32'd1;
        else             step = $urandom;
        w = tick_word(now_sh + step);
      end else if (r < 93) begin
        w = noise_word();
        w.command = CMD_SUBMIT;
      end else begin
        w = noise_word();
        if ($urandom_range(0, 1) == 0) w.command = OP_NONE;
      end
      send_word(w);
      if (w.command != OP_NONE) k++;
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg_t c;
    int   i;
    rst_n = 1'b0;
    push = 1'b0;
    in_word = '0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fail_cnt = 0;
    pop_wait = 0;
    quiet = 1'b0;
    // register and table state after reset
    regs_sh.local_node = 8'd0;
    regs_sh.default_timeout = 32'd1000;
    regs_sh.broadcast_node = 8'd255;
    regs_sh.min_node = 8'd1;
    regs_sh.max_node = 8'd254;
    regs_sh.timeout_code = 8'd0;
    for (i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    next_rid = 8'd1;
    now_sh = 32'd0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();

    // moderate timeout, wide node range
    c.local_node = 8'h5A;
    c.default_timeout = 32'd50;
    c.broadcast_node = 8'hFF;
    c.min_node = 8'h01;
    c.max_node = 8'hFE;
    c.timeout_code = 8'hEE;
    test_random_traffic(c, 22);

    // zero timeout, every node valid, broadcast at zero
    c.local_node = 8'hFF;
    c.default_timeout = 32'd0;
    c.broadcast_node = 8'h00;
    c.min_node = 8'h00;
    c.max_node = 8'hFF;
    c.timeout_code = 8'hFF;
    test_random_traffic(c, 22);

    // longest timeout, empty unicast range
    c.local_node = 8'h00;
    c.default_timeout = 32'hFFFF_FFFF;
    c.broadcast_node = 8'h80;
    c.min_node = 8'hC8;
    c.max_node = 8'h64;
    c.timeout_code = 8'h00;
    test_random_traffic(c, 22);

    c.local_node = rand8();
    c.default_timeout = 32'($urandom_range(1, 3000));
    c.broadcast_node = rand8();
    c.min_node = 8'($urandom_range(0, 100));
    c.max_node = 8'($urandom_range(100, 255));
    c.timeout_code = rand8();
    test_random_traffic(c, 22);

    drain(24);
    if (fail_cnt == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
